// ===== design/tcgi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the tilt-corrected gyro integrator.
// Depends on nothing; every other file of the block imports it.
package tcgi_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam int TS_W     = 63;              // timestamp width
    localparam int DW       = 56;              // CORDIC datapath width
    localparam int ZW       = 34;              // angle width inside CORDIC, Q30 radians
    localparam int ROOT_W   = 32;              // square root result width
    localparam int PROD_W   = DW + TS_W;       // rate times delta product width
    localparam int DROP_W   = 25;              // power of two part of 2^16 * 1e9
    localparam int DIV_BITS = PROD_W - DROP_W; // product bits fed to the divider
    localparam int DV_W     = 21;              // divisor width
    localparam int Q_W      = 34;              // quotient width before the clamp
    localparam int GAIN_W   = 30;
    localparam int CNT_W    = 7;

    localparam logic signed [ZW-1:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic [GAIN_W-1:0]    GAIN_INV_Q30 = 30'd652032874;
    localparam logic [DV_W-1:0]      NS_ODD_DIV   = 21'd1953125;
    localparam logic [Q_W-1:0]       INC_CLAMP    = 34'h2_0000_0000;

    typedef struct packed {
        logic               opcode;
        logic [TS_W-1:0]    timestamp_ns;
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
    } tcgi_in_t;

    typedef struct packed {
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic               integrated;
    } tcgi_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE_Y,
        ST_SQUARE_Z,
        ST_SQRT,
        ST_ROLL,
        ST_PITCH,
        ST_ROT1,
        ST_GAIN1,
        ST_ROT2,
        ST_GAIN2,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } tcgi_state_t;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Arctangent of 2^-i in units of 2^-30 rad, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            5'd24: v = 34'sd64;
            5'd25: v = 34'sd32;
            5'd26: v = 34'sd16;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            5'd30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/tilt_corrected_gyro_integrator_unit.sv =====
`timescale 1ns / 1ps
// Tilt-corrected gyro integrator: top level with the whole datapath and sequencer.
// Depends on tcgi_pkg for the item structs, the state enum and the constants.
//
// Usage. Sensor items enter on the sample channel (sample_valid / sample_ready,
// payload sample) and one result item per input item leaves on the result channel
// (result_valid / result_ready, payload result). The block works on one item at a
// time: sample_ready is high only while the sequencer is idle.
// A clear item, or the first sensor item after reset, goes from acceptance straight
// to the done state, where its result is loaded. A sensor item that integrates
// passes through one shared CORDIC unit doing one iteration a cycle (four passes),
// a restoring square root that yields one root bit per step, a bit-serial gain
// multiply per rotation, and for each of the three axes a bit-serial rate times
// delta multiply followed by a bit-serial division by 1953125.
// Reset clears the angles, the stored time and the flag that a time is stored;
// the block comes out of reset idle with no result pending.
// The result sits in an output register. While the receiver stalls it holds, and
// the block still accepts and works on the next item; that item's result waits in
// the done state until the output register is free.
module tilt_corrected_gyro_integrator_unit
    import tcgi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_ready,
    input  tcgi_in_t  sample,
    output logic      result_valid,
    input  logic      result_ready,
    output tcgi_out_t result
);

    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] GAIN_LAST   = CNT_W'(GAIN_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST    = CNT_W'(TS_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_BITS - 1);

    // Start values of one CORDIC pass after the quadrant pre-rotation.
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cload_t;

    function automatic cload_t vec_prep(input logic signed [DW-1:0] y,
                                        input logic signed [DW-1:0] x);
        cload_t c;
        c.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            if (y >= 0) begin
                c.x = y;
                c.y = -x;
                c.z = HALF_PI_Q30;
            end else begin
                c.x = -y;
                c.y = x;
                c.z = -HALF_PI_Q30;
            end
        end else begin
            c.x = x;
            c.y = y;
            c.z = '0;
        end
        return c;
    endfunction

    function automatic cload_t rot_prep(input logic signed [DW-1:0] a,
                                        input logic signed [DW-1:0] b,
                                        input logic signed [ZW-1:0] z);
        cload_t c;
        c.zero = 1'b0;
        if (z > HALF_PI_Q30) begin
            c.x = -b;
            c.y = a;
            c.z = z - HALF_PI_Q30;
        end else if (z < -HALF_PI_Q30) begin
            c.x = b;
            c.y = -a;
            c.z = z + HALF_PI_Q30;
        end else begin
            c.x = a;
            c.y = b;
            c.z = z;
        end
        return c;
    endfunction

    function automatic logic signed [DW-1:0] q16_to_dp(input logic signed [31:0] v);
        return {{(DW - 48){v[31]}}, v, 16'b0};
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    tcgi_state_t state_reg, state_next;

    tcgi_in_t             smp_reg, smp_next;
    logic [TS_W-1:0]      prev_time_reg, prev_time_next;
    logic                 have_prev_reg, have_prev_next;
    logic signed [31:0]   ang_reg [3];
    logic signed [31:0]   ang_next [3];
    logic                 integ_reg, integ_next;
    logic [TS_W-1:0]      dmag_reg, dmag_next;
    logic                 dneg_reg, dneg_next;

    logic [63:0]          sq_reg, sq_next;
    logic [33:0]          rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;

    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 zero_reg, zero_next;
    logic signed [ZW-1:0] roll_reg, roll_next;
    logic signed [ZW-1:0] pitch_reg, pitch_next;
    logic signed [DW-1:0] ga_reg, ga_next;
    logic signed [DW-1:0] gb_reg, gb_next;
    logic signed [DW-1:0] w_reg [3];
    logic signed [DW-1:0] w_next [3];
    logic [1:0]           k_reg, k_next;

    logic [DW-1:0]        mc_reg, mc_next;
    logic                 neg_reg, neg_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [DV_W-1:0]      drem_reg, drem_next;
    logic [Q_W-1:0]       q_reg, q_next;
    logic                 qovf_reg, qovf_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 out_valid_reg, out_valid_next;
    tcgi_out_t            out_reg, out_next;

    // Shared step logic; each piece only matters in the states that use it.
    logic [4:0]           sh;
    logic                 vec_mode;
    logic                 ccw;
    logic signed [DW-1:0] sx, sy, x_step, y_step;
    logic signed [ZW-1:0] atan_v, z_step, z_result;
    logic [35:0]          sq_win, sq_trial;
    logic                 gain_bit;
    logic signed [DW:0]   gsum_a, gsum_b;
    logic signed [DW-1:0] ga_step, gb_step;
    logic [DW:0]          msum;
    logic [DV_W:0]        dtrial;
    logic                 dge;
    logic [Q_W-1:0]       mag;
    logic signed [Q_W:0]  inc;
    logic signed [35:0]   asum;
    logic signed [31:0]   asat;
    logic signed [31:0]   ang_k;
    logic signed [DW-1:0] w_k;
    logic [TS_W:0]        delta;
    logic                 accept;
    logic                 out_free;
    cload_t               ld_pitch, ld_roll, ld_rot1, ld_rot2;

    assign sh       = cnt_reg[4:0];
    assign vec_mode = (state_reg == ST_ROLL) || (state_reg == ST_PITCH);
    assign ccw      = vec_mode ? y_reg[DW-1] : !z_reg[ZW-1];
    assign sx       = x_reg >>> sh;
    assign sy       = y_reg >>> sh;
    assign atan_v   = atan_q30(sh);
    assign x_step   = ccw ? x_reg - sy : x_reg + sy;
    assign y_step   = ccw ? y_reg + sx : y_reg - sx;
    assign z_step   = ccw ? z_reg - atan_v : z_reg + atan_v;
    assign z_result = zero_reg ? '0 : z_step;

    // Restoring square root, one root bit per step: two radicand bits enter per cycle.
    assign sq_win   = {rem_reg, sq_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    // Multiply by the constant gain one bit at a time, LSB first, halving as we go,
    // which leaves the floor of v * gain / 2^30 after the last bit.
    assign gain_bit = GAIN_INV_Q30[sh];
    assign gsum_a   = {ga_reg[DW-1], ga_reg} + (gain_bit ? {x_reg[DW-1], x_reg} : '0);
    assign gsum_b   = {gb_reg[DW-1], gb_reg} + (gain_bit ? {y_reg[DW-1], y_reg} : '0);
    assign ga_step  = gsum_a[DW:1];
    assign gb_step  = gsum_b[DW:1];

    // Shift-add multiply of |rate| by |delta|; the delta bits shift out at the bottom.
    assign msum   = {1'b0, prod_reg[PROD_W-1:TS_W]} + (prod_reg[0] ? {1'b0, mc_reg} : '0);

    // Bit-serial long division of the product (low 25 bits dropped) by 1953125.
    assign dtrial = {drem_reg, prod_reg[PROD_W-1]};
    assign dge    = dtrial >= {1'b0, NS_ODD_DIV};

    assign mag   = (qovf_reg || (q_reg > INC_CLAMP)) ? INC_CLAMP : q_reg;
    assign inc   = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign ang_k = ang_reg[k_reg];
    assign w_k   = w_reg[k_reg];
    assign asum  = {{4{ang_k[31]}}, ang_k} + {inc[Q_W], inc};
    assign asat  = (asum > 36'sh0_7FFF_FFFF)  ? 32'sh7FFF_FFFF :
                   (asum < -36'sh0_8000_0000) ? 32'sh8000_0000 : asum[31:0];

    assign delta = {1'b0, sample.timestamp_ns} - {1'b0, prev_time_reg};

    assign ld_roll  = vec_prep(q16_to_dp(smp_reg.accel_y), q16_to_dp(smp_reg.accel_z));
    assign ld_pitch = vec_prep(-q16_to_dp(smp_reg.accel_x),
                               {{(DW - ROOT_W - 16){1'b0}}, root_reg, 16'b0});
    assign ld_rot1  = rot_prep(q16_to_dp(smp_reg.gyro_y), q16_to_dp(smp_reg.gyro_z),
                               roll_reg);
    assign ld_rot2  = rot_prep(gb_step, q16_to_dp(smp_reg.gyro_x), pitch_reg);

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_time_reg <= '0;
            have_prev_reg <= 1'b0;
            ang_reg[0]    <= '0;
            ang_reg[1]    <= '0;
            ang_reg[2]    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_time_reg <= prev_time_next;
            have_prev_reg <= have_prev_next;
            ang_reg       <= ang_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        integ_reg <= integ_next;
        dmag_reg  <= dmag_next;
        dneg_reg  <= dneg_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        zero_reg  <= zero_next;
        roll_reg  <= roll_next;
        pitch_reg <= pitch_next;
        ga_reg    <= ga_next;
        gb_reg    <= gb_next;
        w_reg     <= w_next;
        k_reg     <= k_next;
        mc_reg    <= mc_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        drem_reg  <= drem_next;
        q_reg     <= q_next;
        qovf_reg  <= qovf_next;
        cnt_reg   <= cnt_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        smp_next       = smp_reg;
        prev_time_next = prev_time_reg;
        have_prev_next = have_prev_reg;
        ang_next       = ang_reg;
        integ_next     = integ_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zero_next      = zero_reg;
        roll_next      = roll_reg;
        pitch_next     = pitch_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        w_next         = w_reg;
        k_next         = k_reg;
        mc_next        = mc_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        drem_next      = drem_reg;
        q_next         = q_reg;
        qovf_next      = qovf_reg;
        cnt_next       = cnt_reg + 1'b1;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    smp_next   = sample;
                    integ_next = 1'b0;
                    if (sample.opcode == OP_CLEAR)
                    begin
                        ang_next[0] = '0;
                        ang_next[1] = '0;
                        ang_next[2] = '0;
                        state_next  = ST_DONE;
                    end
                    else if (!have_prev_reg)
                    begin
                        prev_time_next = sample.timestamp_ns;
                        have_prev_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        // The difference of two 63-bit times always fits 64 signed bits.
                        dneg_next      = delta[TS_W];
                        dmag_next      = delta[TS_W] ? TS_W'(-delta) : delta[TS_W-1:0];
                        prev_time_next = sample.timestamp_ns;
                        integ_next     = 1'b1;
                        state_next     = ST_SQUARE_Y;
                    end
                end
            end
            ST_SQUARE_Y:
            begin
                sq_next    = abs32(smp_reg.accel_y) * abs32(smp_reg.accel_y);
                state_next = ST_SQUARE_Z;
            end
            ST_SQUARE_Z:
            begin
                sq_next    = sq_reg + abs32(smp_reg.accel_z) * abs32(smp_reg.accel_z);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                sq_next = {sq_reg[61:0], 2'b00};
                if (sq_win >= sq_trial)
                begin
                    rem_next  = 34'(sq_win - sq_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_win[33:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (cnt_reg == SQRT_LAST)
                begin
                    x_next     = ld_roll.x;
                    y_next     = ld_roll.y;
                    z_next     = ld_roll.z;
                    zero_next  = ld_roll.zero;
                    cnt_next   = '0;
                    state_next = ST_ROLL;
                end
            end
            ST_ROLL:
            begin
                x_next = x_step;
                y_next = y_step;
                z_next = z_step;
                if (cnt_reg == CORDIC_LAST)
                begin
                    roll_next  = z_result;
                    x_next     = ld_pitch.x;
                    y_next     = ld_pitch.y;
                    z_next     = ld_pitch.z;
                    zero_next  = ld_pitch.zero;
                    cnt_next   = '0;
                    state_next = ST_PITCH;
                end
            end
            ST_PITCH:
            begin
                x_next = x_step;
                y_next = y_step;
                z_next = z_step;
                if (cnt_reg == CORDIC_LAST)
                begin
                    pitch_next = z_result;
                    x_next     = ld_rot1.x;
                    y_next     = ld_rot1.y;
                    z_next     = ld_rot1.z;
                    cnt_next   = '0;
                    state_next = ST_ROT1;
                end
            end
            ST_ROT1, ST_ROT2:
            begin
                x_next = x_step;
                y_next = y_step;
                z_next = z_step;
                if (cnt_reg == CORDIC_LAST)
                begin
                    ga_next    = '0;
                    gb_next    = '0;
                    cnt_next   = '0;
                    state_next = (state_reg == ST_ROT1) ? ST_GAIN1 : ST_GAIN2;
                end
            end
            ST_GAIN1:
            begin
                ga_next = ga_step;
                gb_next = gb_step;
                if (cnt_reg == GAIN_LAST)
                begin
                    // Roll-corrected y goes out; roll-corrected z feeds the pitch turn.
                    w_next[1]  = ga_step;
                    x_next     = ld_rot2.x;
                    y_next     = ld_rot2.y;
                    z_next     = ld_rot2.z;
                    cnt_next   = '0;
                    state_next = ST_ROT2;
                end
            end
            ST_GAIN2:
            begin
                ga_next = ga_step;
                gb_next = gb_step;
                if (cnt_reg == GAIN_LAST)
                begin
                    w_next[0]  = gb_step;
                    w_next[2]  = ga_step;
                    k_next     = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mc_next    = w_k[DW-1] ? DW'(-w_k) : w_k;
                neg_next   = w_k[DW-1] ^ dneg_reg;
                prod_next  = {{DW{1'b0}}, dmag_reg};
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next = {msum, prod_reg[TS_W-1:1]};
                if (cnt_reg == MUL_LAST)
                begin
                    drem_next  = '0;
                    q_next     = '0;
                    qovf_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
                drem_next = dge ? DV_W'(dtrial - {1'b0, NS_ODD_DIV}) : dtrial[DV_W-1:0];
                q_next    = {q_reg[Q_W-2:0], dge};
                qovf_next = qovf_reg || q_reg[Q_W-1];
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                ang_next[k_reg] = asat;
                if (k_reg == 2'd2)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next.angle_x    = ang_reg[0];
                    out_next.angle_y    = ang_reg[1];
                    out_next.angle_z    = ang_reg[2];
                    out_next.integrated = integ_reg;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sim/tcgi_checker.sv =====
`timescale 1ns / 1ps
// Checker for the tilt-corrected gyro integrator: watches both channels,
// predicts each result item and compares it with what the block returns.
// Depends on tcgi_pkg for the item structs, the opcodes and the step count.
module tcgi_checker
    import tcgi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    input  logic      sample_ready,
    input  tcgi_in_t  sample,
    input  logic      result_valid,
    input  logic      result_ready,
    input  tcgi_out_t result,
    output int        error_count,
    output int        outstanding
);

    localparam longint HALF_PI   = 64'sd1686629713;
    localparam longint GAIN_INV  = 64'sd652032874;
    localparam longint RATE_CLIP = 64'sd8589934592;
    localparam longint ARCTAN [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0};

    logic [TS_W-1:0]    last_time;
    logic               time_known;
    logic signed [31:0] angle [3];
    tcgi_out_t          angle_queue [$];

    function automatic longint gain_trim(longint v);
        longint hi;
        longint lo;
        hi = v >>> 30;
        lo = v - hi * 64'sd1073741824;
        return hi * GAIN_INV + ((lo * GAIN_INV) >>> 30);
    endfunction

    function automatic longint root_floor(longint unsigned num);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > num) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (num >= res + bitv) begin
                num = num - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_PI;
            end else begin
                x = -y; y = t; z = -HALF_PI;
            end
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ARCTAN[i % 32];
            end else begin
                x -= dx; y += dy; z -= ARCTAN[i % 32];
            end
        end
        return z;
    endfunction

    function automatic void rotate_pair(inout longint a, inout longint b, input longint z);
        longint t;
        longint da;
        longint db;
        if (z > HALF_PI) begin
            t = a; a = -b; b = t; z -= HALF_PI;
        end else if (z < -HALF_PI) begin
            t = a; a = b; b = -t; z += HALF_PI;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (z >= 0) begin
                a -= da; b += db; z -= ARCTAN[i % 32];
            end else begin
                a += da; b -= db; z += ARCTAN[i % 32];
            end
        end
        a = gain_trim(a);
        b = gain_trim(b);
    endfunction

    // Rate times elapsed ns, scaled to Q16.16 radians, magnitude clipped.
    function automatic longint angle_step(longint r, longint d);
        logic          neg;
        logic [127:0]  ma;
        logic [127:0]  mb;
        logic [127:0]  q;
        longint        mag;
        neg = (r < 0) != (d < 0);
        ma = {64'd0, (r < 0) ? 64'd0 - r : r};
        mb = {64'd0, (d < 0) ? 64'd0 - d : d};
        q = ((ma * mb) >> 25) / 128'd1953125;
        mag = (q > 128'(RATE_CLIP)) ? RATE_CLIP : longint'(q[63:0]);
        return neg ? -mag : mag;
    endfunction

    function automatic tcgi_out_t predict_angles(tcgi_in_t s);
        tcgi_out_t o;
        longint    ay, az, rad, roll, pitch, d, a, b, c, e, s_sum;
        longint    w [3];
        o.integrated = 1'b0;
        if (s.opcode == OP_CLEAR) begin
            for (int k = 0; k < 3; k++) angle[k] = '0;
        end else begin
            if (time_known) begin
                ay = s.accel_y;
                az = s.accel_z;
                rad = root_floor(longint'(ay * ay + az * az));
                roll = vector_angle(ay * 65536, az * 65536);
                pitch = vector_angle(-longint'(s.accel_x) * 65536, rad * 65536);
                d = longint'({1'b0, s.timestamp_ns}) - longint'({1'b0, last_time});
                a = longint'(s.gyro_y) * 65536;
                b = longint'(s.gyro_z) * 65536;
                rotate_pair(a, b, roll);
                c = b;
                e = longint'(s.gyro_x) * 65536;
                rotate_pair(c, e, pitch);
                w[0] = e; w[1] = a; w[2] = c;
                for (int k = 0; k < 3; k++) begin
                    s_sum = longint'(angle[k]) + angle_step(w[k], d);
                    if (s_sum > 64'sd2147483647) s_sum = 64'sd2147483647;
                    if (s_sum < -64'sd2147483648) s_sum = -64'sd2147483648;
                    angle[k] = s_sum[31:0];
                end
                o.integrated = 1'b1;
            end
            last_time = s.timestamp_ns;
            time_known = 1'b1;
        end
        o.angle_x = angle[0];
        o.angle_y = angle[1];
        o.angle_z = angle[2];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    initial begin
        error_count = 0;
        time_known = 1'b0;
        last_time = '0;
        for (int k = 0; k < 3; k++) angle[k] = '0;
    end

    always @(posedge clk) begin
        tcgi_out_t want;
        if (rst_n) begin
            if (sample_valid && sample_ready)
                angle_queue.insert(angle_queue.size(), predict_angles(sample));
            if (result_valid && result_ready) begin
                if (angle_queue.size() == 0) begin
                    report_mismatch("result with nothing expected", 1, 0);
                end else begin
                    want = angle_queue.pop_front();
                    if (result.angle_x !== want.angle_x)
                        report_mismatch("angle_x", result.angle_x, want.angle_x);
                    if (result.angle_y !== want.angle_y)
                        report_mismatch("angle_y", result.angle_y, want.angle_y);
                    if (result.angle_z !== want.angle_z)
                        report_mismatch("angle_z", result.angle_z, want.angle_z);
                    if (result.integrated !== want.integrated)
                        report_mismatch("integrated", result.integrated, want.integrated);
                end
            end
        end
        outstanding <= angle_queue.size();
    end

    initial outstanding = 0;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the tilt-corrected gyro integrator: makes the sample
// items, the receiver stalls and the verdict. Depends on tcgi_pkg, the block
// and tcgi_checker, which does all prediction and comparison.
module tb
    import tcgi_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int LONG_HOLD      = 3000;

    logic      clk;
    logic      rst_n;
    logic      sample_valid;
    logic      sample_ready;
    tcgi_in_t  sample;
    logic      result_valid;
    logic      result_ready;
    tcgi_out_t result;
    int        error_count;
    int        outstanding;

    // Idling is switched off for the last part of the run. The long hold is
    // requested by the stimulus and timed by the receiver process itself.
    logic      idle_on;
    logic      hold_req;
    int        quiet_cycles;
    logic [TS_W-1:0] now_ns;

    tilt_corrected_gyro_integrator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    tcgi_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .error_count  (error_count),
        .outstanding  (outstanding)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // The watchdog counts cycles in which no item moves on either channel.
    always @(posedge clk) begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: either ready, a short random stall, or the one long hold.
    // Every branch makes at most one assignment per falling edge.
    initial begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                result_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge clk);
            end else begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 40)) @(negedge clk);
            end
        end
    end

    function automatic tcgi_in_t make_item(logic op, logic [TS_W-1:0] ts,
                                           logic [31:0] gx, logic [31:0] gy,
                                           logic [31:0] gz, logic [31:0] ax,
                                           logic [31:0] ay, logic [31:0] az);
        tcgi_in_t it;
        it.opcode = op;
        it.timestamp_ns = ts;
        it.gyro_x = gx;
        it.gyro_y = gy;
        it.gyro_z = gz;
        it.accel_x = ax;
        it.accel_y = ay;
        it.accel_z = az;
        return it;
    endfunction

    // Called and returning at a falling edge. The valid stays high between
    // back-to-back items, so it is never dropped and raised in one step.
    task automatic offer_item(tcgi_in_t it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= it;
        do @(posedge clk); while (!sample_ready);
        @(negedge clk);
    endtask

    // Sensor value: mostly in a realistic range, sometimes any 32-bit pattern.
    function automatic logic [31:0] sensor_value(int span);
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [TS_W-1:0] rand_ts();
        return TS_W'({$urandom, $urandom});
    endfunction

    initial begin
        tcgi_in_t it;
        logic [TS_W-1:0] step_ns;
        int pick;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        quiet_cycles = 0;
        now_ns = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: clear at reset, the first sample that only stores its
        // time, field extremes, zero accel vector, backwards and equal times,
        // and a huge time step that clips the increment and saturates angles.
        offer_item(make_item(OP_CLEAR, '1, '1, '1, '1, '1, '1, '1));
        offer_item(make_item(OP_SAMPLE, 63'd1000, 32'h7fff_ffff, 0, 0, 0, 0, 32'h0009_cf5c));
        offer_item(make_item(OP_SAMPLE, 63'd1_001_000, 32'h0001_0000, 32'h0002_0000,
                             32'hfffd_0000, 0, 0, 0));
        offer_item(make_item(OP_SAMPLE, 63'd2_001_000, 32'h7fff_ffff, 32'h8000_0000,
                             32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        offer_item(make_item(OP_SAMPLE, 63'd3_001_000, 32'h8000_0000, 32'h7fff_ffff,
                             32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        offer_item(make_item(OP_SAMPLE, 63'd3_001_000, 32'h0010_0000, 32'h0010_0000,
                             32'h0010_0000, 32'h0001_0000, 0, 32'hffff_0000));
        offer_item(make_item(OP_SAMPLE, 63'd1_000, 32'h0010_0000, 32'hfff0_0000,
                             32'h0003_0000, 0, 32'hffff_0000, 32'hffff_0000));
        offer_item(make_item(OP_SAMPLE, '1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             0, 0, 32'h0009_cf5c));
        offer_item(make_item(OP_SAMPLE, '1, 1, 1, 1, 1, 1, 1));
        offer_item(make_item(OP_SAMPLE, 63'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        offer_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        offer_item(make_item(OP_SAMPLE, 63'd5_000_000, 32'h0003_243f, 0, 0,
                             32'hfff6_3000, 0, 0));
        offer_item(make_item(OP_SAMPLE, 63'd6_000_000, 32'h0003_243f, 32'h0001_0000, 0,
                             0, 32'h0009_cf5c, 0));

        // Pressure: hold the receiver off while cheap clear items keep coming,
        // so the output register and the done state fill and sample_ready drops.
        hold_req = 1'b1;
        for (int n = 0; n < 8; n++)
            offer_item(make_item(OP_CLEAR, rand_ts(), $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom));

        now_ns = 63'd6_000_000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - 200) idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                it = make_item(OP_CLEAR, rand_ts(), $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom);
            end else begin
                if (pick < 8)
                    now_ns = rand_ts();
                else if (pick < 11)
                    now_ns = now_ns - TS_W'($urandom_range(0, 2_000_000));
                else if (pick < 16)
                    now_ns = now_ns + TS_W'({$urandom_range(0, 255), $urandom});
                else begin
                    step_ns = TS_W'($urandom_range(500_000, 2_000_000));
                    now_ns = now_ns + step_ns;
                end
                it = make_item(OP_SAMPLE, now_ns,
                               sensor_value(1_000_000), sensor_value(1_000_000),
                               sensor_value(1_000_000), sensor_value(1_300_000),
                               sensor_value(1_300_000), sensor_value(1_300_000));
            end
            offer_item(it);
        end
        sample_valid <= 1'b0;

        // Drain: wait for every expected result item, then a short settle.
        while (outstanding != 0 || result_valid) @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
